// ===== sv/nsp_pkg.sv =====
// ----------------------------------------------------------------------------
// nsp_pkg - shared types and constants of the nibble sample playback channel
// Request and result payloads, register map, sequencer states and the
// nibble-to-sample conversion table.
// ----------------------------------------------------------------------------
`default_nettype none

package nsp_pkg;

    localparam logic [31:0] PHASE_CLOCK_DEF = 32'd732064;
    localparam int          ADDR_BITS_DEF   = 16;
    localparam int          CFG_ADDR_W      = 5;
    localparam int          CFG_DATA_W      = 32;
    localparam logic [7:0]  LOOP_FOREVER    = 8'hFF;

    // Operation codes of an input request
    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_START = 2'd1,
        OP_TICK  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    // Register indexes (byte address / 4)
    typedef enum logic [2:0] {
        REG_START_ADDRESS  = 3'd0,
        REG_END_ADDRESS    = 3'd1,
        REG_REPEAT_COUNT   = 3'd2,
        REG_REPEAT_ADDRESS = 3'd3,
        REG_NIBBLE_ORDER   = 3'd4,
        REG_PERIOD_SCALE   = 3'd5,
        REG_PERIOD         = 3'd6,
        REG_VOLUME_SHIFT   = 3'd7
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DATA
    } t_back_state;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] mem_address;
        logic [7:0]  mem_data;
    } t_in_item;

    typedef struct packed {
        logic signed [7:0] sample_out;
        logic              channel_active;
    } t_out_item;

    // Classified request as held in the queue
    typedef struct packed {
        t_op         kind;
        logic [15:0] mem_address;
        logic [7:0]  mem_data;
    } t_req;

    typedef struct packed {
        logic [15:0] start_address;
        logic [15:0] end_address;
        logic [7:0]  repeat_count;
        logic [15:0] repeat_address;
        logic        nibble_order;
        logic [7:0]  period_scale;
        logic [15:0] period;
        logic [1:0]  volume_shift;
    } t_cfg;

    function automatic logic signed [7:0] nib_to_sample(input logic [3:0] nib);
        logic [7:0] v;
        unique case (nib)
            4'h0: v = 8'h81;
            4'h1: v = 8'h90;
            4'h2: v = 8'hA0;
            4'h3: v = 8'hB0;
            4'h4: v = 8'hC0;
            4'h5: v = 8'hD0;
            4'h6: v = 8'hE0;
            4'h7: v = 8'hF0;
            4'h8: v = 8'h00;
            4'h9: v = 8'h10;
            4'hA: v = 8'h20;
            4'hB: v = 8'h30;
            4'hC: v = 8'h40;
            4'hD: v = 8'h50;
            4'hE: v = 8'h60;
            4'hF: v = 8'h70;
            default: v = 8'h00;
        endcase
        return $signed(v);
    endfunction

endpackage

`default_nettype wire

// ===== sv/nsp_ram.sv =====
// ----------------------------------------------------------------------------
// nsp_ram - generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module nsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== sv/nsp_front.sv =====
// ----------------------------------------------------------------------------
// nsp_front - request intake
// Accept input requests, classify the operation and queue them for the
// execution side.
// ----------------------------------------------------------------------------
`default_nettype none

module nsp_front
    import nsp_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    input  wire t_in_item i_in_req,
    output logic          o_in_stall,
    output logic          o_req_valid,
    output t_req          o_req,
    input  wire logic     i_pop
);

    localparam int QDEPTH = 2;
    localparam int PTR_W  = $clog2(QDEPTH);
    localparam int CNT_W  = $clog2(QDEPTH + 1);

    t_req             r_q [QDEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             push;
    logic             pop;
    t_req             cls;

    // Classify the operation code
    always_comb begin
        cls.mem_address = i_in_req.mem_address;
        cls.mem_data    = i_in_req.mem_data;
        unique case (i_in_req.operation)
            OP_WRITE: cls.kind = OP_WRITE;
            OP_START: cls.kind = OP_START;
            OP_TICK:  cls.kind = OP_TICK;
            default:  cls.kind = OP_NONE;
        endcase
    end

    assign o_in_stall  = (r_count == CNT_W'(QDEPTH));
    assign push        = i_in_valid && !o_in_stall;
    assign pop         = i_pop && o_req_valid;
    assign o_req_valid = (r_count != '0);
    assign o_req       = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (pop && !push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/nsp_div.sv =====
// ----------------------------------------------------------------------------
// nsp_div - phase step divider
// Restoring divider, one quotient bit per cycle: PHASE_CLOCK / divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module nsp_div
    import nsp_pkg::*;
#(
    parameter logic [31:0] PHASE_CLOCK = PHASE_CLOCK_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [15:0] i_divisor,
    output logic             o_busy,
    output logic [31:0]      o_quotient
);

    logic [31:0] r_quo;
    logic [15:0] r_rem;
    logic [15:0] r_div;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic [16:0] rem_sh;
    logic [16:0] diff;
    logic        fits;

    assign rem_sh = {r_rem, r_quo[31]};
    assign diff   = rem_sh - {1'b0, r_div};
    assign fits   = (rem_sh >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= PHASE_CLOCK;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[30:0], fits};
            r_rem <= fits ? diff[15:0] : rem_sh[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '1;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 5'd1;
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

// ===== sv/nsp_back.sv =====
// ----------------------------------------------------------------------------
// nsp_back - execution sequencer
// Carry out queued requests: memory writes, channel starts and sample ticks,
// and hold the result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module nsp_back
    import nsp_pkg::*;
#(
    parameter logic [31:0] PHASE_CLOCK = PHASE_CLOCK_DEF,
    parameter int          ADDR_BITS   = ADDR_BITS_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_cfg      i_cfg,
    input  wire logic      i_req_valid,
    input  wire t_req      i_req,
    output logic           o_pop,
    output logic           o_out_valid,
    output t_out_item      o_out_res,
    input  wire logic      i_out_stall
);

    localparam int DEPTH = 1 << ADDR_BITS;

    t_back_state r_state, n_state;
    logic        r_playing, n_playing;
    logic [31:0] r_phase, n_phase;
    logic [31:0] r_step, n_step;
    logic [15:0] r_base, n_base;
    logic [7:0]  r_loops, n_loops;
    logic [15:0] r_last_period, n_last_period;
    logic        r_high, n_high;
    logic        r_out_valid, n_out_valid;
    t_out_item   r_out_res, n_out_res;

    logic        out_free;
    logic        ram_we;
    logic        ram_re;
    logic [15:0] rd_idx;
    logic [7:0]  ram_rdata;
    logic        div_start;
    logic        div_busy;
    logic [31:0] div_quo;
    logic [15:0] scaled;
    logic [15:0] idx;
    logic [31:0] phase_eff;
    logic        stop;
    logic [3:0]  nib;
    logic signed [7:0] smp;

    nsp_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_req.mem_address[ADDR_BITS-1:0]),
        .i_wdata (i_req.mem_data),
        .i_re    (ram_re),
        .i_raddr (rd_idx[ADDR_BITS-1:0]),
        .o_rdata (ram_rdata)
    );

    nsp_div #(
        .PHASE_CLOCK (PHASE_CLOCK)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_divisor  (scaled),
        .o_busy     (div_busy),
        .o_quotient (div_quo)
    );

    assign out_free = !r_out_valid || !i_out_stall;
    assign scaled   = (i_cfg.period_scale[7:4] != '0) ? 16'd0
                      : (i_cfg.period >> i_cfg.period_scale[3:0]);
    assign idx      = r_phase[31:16] + r_base;
    assign nib      = r_high ? ram_rdata[7:4] : ram_rdata[3:0];
    assign smp      = nib_to_sample(nib) >>> i_cfg.volume_shift;

    // End-of-range handling for a tick
    always_comb begin
        stop      = 1'b0;
        phase_eff = r_phase;
        n_base    = r_base;
        n_loops   = r_loops;
        rd_idx    = idx;
        if (idx >= i_cfg.end_address) begin
            if (r_loops != LOOP_FOREVER && r_loops == '0) begin
                stop = 1'b1;
            end else begin
                if (r_loops != LOOP_FOREVER) begin
                    n_loops = r_loops - 8'd1;
                end
                n_base    = i_cfg.repeat_address;
                rd_idx    = i_cfg.repeat_address;
                phase_eff = '0;
                if (i_cfg.repeat_address >= i_cfg.end_address) begin
                    stop = 1'b1;
                end
            end
        end
    end

    always_comb begin
        n_state       = r_state;
        n_playing     = r_playing;
        n_phase       = r_phase;
        n_step        = r_step;
        n_last_period = r_last_period;
        n_high        = r_high;
        n_out_valid   = r_out_valid && i_out_stall;
        n_out_res     = r_out_res;
        o_pop         = 1'b0;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        div_start     = 1'b0;
        // keep tick bookkeeping unless a tick or a start commits it
        unique case (r_state)
            ST_IDLE: begin
                if (i_req_valid && out_free) begin
                    o_pop                    = 1'b1;
                    n_out_valid              = 1'b1;
                    n_out_res.sample_out     = '0;
                    n_out_res.channel_active = r_playing;
                    unique case (i_req.kind)
                        OP_WRITE: begin
                            ram_we = 1'b1;
                        end
                        OP_START: begin
                            if (i_cfg.end_address > i_cfg.start_address) begin
                                n_phase = '0;
                                if (scaled == '0) begin
                                    n_playing     = 1'b0;
                                    n_step        = '0;
                                    n_last_period = '0;
                                    n_out_res.channel_active = 1'b0;
                                end else begin
                                    n_playing = 1'b1;
                                    n_out_res.channel_active = 1'b1;
                                    if (scaled != r_last_period) begin
                                        n_last_period = scaled;
                                        div_start     = 1'b1;
                                        n_out_valid   = 1'b0;
                                        n_state       = ST_DIV;
                                    end
                                end
                            end
                        end
                        OP_TICK: begin
                            if (r_playing) begin
                                if (stop) begin
                                    n_playing = 1'b0;
                                    n_phase   = phase_eff;
                                    n_out_res.channel_active = 1'b0;
                                end else begin
                                    ram_re      = 1'b1;
                                    n_phase     = phase_eff + r_step;
                                    n_high      = (i_cfg.period_scale != '0)
                                                  ? i_cfg.nibble_order
                                                  : (phase_eff[15] ^ i_cfg.nibble_order);
                                    n_out_valid = 1'b0;
                                    n_state     = ST_DATA;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_DIV: begin
                if (!div_busy && out_free) begin
                    n_step                   = div_quo;
                    n_out_valid              = 1'b1;
                    n_out_res.sample_out     = '0;
                    n_out_res.channel_active = 1'b1;
                    n_state                  = ST_IDLE;
                end
            end
            ST_DATA: begin
                if (out_free) begin
                    n_out_valid              = 1'b1;
                    n_out_res.sample_out     = smp;
                    n_out_res.channel_active = 1'b1;
                    n_state                  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    logic commit_tick;
    assign commit_tick = o_pop && (i_req.kind == OP_TICK) && r_playing;

    always_ff @(posedge i_clk) begin
        r_out_res <= n_out_res;
        r_high    <= n_high;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_playing     <= 1'b0;
            r_phase       <= '0;
            r_step        <= '0;
            r_base        <= '0;
            r_loops       <= '0;
            r_last_period <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_playing     <= n_playing;
            r_phase       <= n_phase;
            r_step        <= n_step;
            r_last_period <= n_last_period;
            r_out_valid   <= n_out_valid;
            if (commit_tick) begin
                r_base  <= n_base;
                r_loops <= n_loops;
            end else if (o_pop && i_req.kind == OP_START
                         && i_cfg.end_address > i_cfg.start_address) begin
                r_base  <= i_cfg.start_address;
                r_loops <= i_cfg.repeat_count;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out_res;

    // The channel is playing for as long as a divide or a memory read is open
    a_div_playing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> r_playing)
        else $error("divide in progress while channel inactive");

    a_data_playing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DATA) |-> r_playing)
        else $error("sample read in progress while channel inactive");

    a_pop_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> out_free)
        else $error("request taken with the result register occupied");

    a_sample_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_res.sample_out != '0) |-> r_out_res.channel_active)
        else $error("nonzero sample from an inactive channel");

    a_data_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DATA && out_free) |=> (r_state == ST_IDLE && r_out_valid))
        else $error("sample read did not complete");

endmodule

`default_nettype wire

// ===== sv/nibble_sample_playback_channel.sv =====
// ----------------------------------------------------------------------------
// nibble_sample_playback_channel - 4-bit packed sample playback channel
// Sample memory, a 16.16 phase accumulator with looping, and an APB
// register file for the channel setup.
// ----------------------------------------------------------------------------
// A request enters a two-entry queue, which registers it, and is carried
// out by the execution sequencer, which returns exactly one result per
// request through an output register. A memory write, a start whose scaled
// period matches the last one, a start that is ignored or has a zero
// period, a tick of an idle channel, a tick that stops the channel and an
// unused operation are finished in the idle state; a tick of a playing
// channel passes through the data state for the registered read of the
// sample memory; a start with a new scaled period passes through the divide
// state while the bit-serial divider forms the phase step (one quotient bit
// per cycle, 32 bits). The sample memory comes out of reset with undefined
// contents and needs no clearing pass: write every byte before a tick reads
// it. Registers sit at byte address 4*index; the user must write them only
// while no request is in flight, as the block itself does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module nibble_sample_playback_channel
    import nsp_pkg::*;
#(
    parameter logic [31:0] PHASE_CLOCK = PHASE_CLOCK_DEF,
    parameter int          ADDR_BITS   = ADDR_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // request channel
    input  wire logic                  i_in_valid,
    input  wire t_in_item              i_in_req,
    output logic                       o_in_stall,
    // result channel
    output logic                       o_out_valid,
    output t_out_item                  o_out_res,
    input  wire logic                  i_out_stall,
    // register port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0]      prdata,
    output logic                       pready
);

    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     cfg_wr;
    logic     req_valid;
    t_req     req;
    logic     pop;

    // Register file: write on the access phase, no wait states
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = t_reg_idx'(paddr[CFG_ADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_START_ADDRESS:  r_cfg.start_address  <= pwdata[15:0];
                REG_END_ADDRESS:    r_cfg.end_address    <= pwdata[15:0];
                REG_REPEAT_COUNT:   r_cfg.repeat_count   <= pwdata[7:0];
                REG_REPEAT_ADDRESS: r_cfg.repeat_address <= pwdata[15:0];
                REG_NIBBLE_ORDER:   r_cfg.nibble_order   <= pwdata[0];
                REG_PERIOD_SCALE:   r_cfg.period_scale   <= pwdata[7:0];
                REG_PERIOD:         r_cfg.period         <= pwdata[15:0];
                REG_VOLUME_SHIFT:   r_cfg.volume_shift   <= pwdata[1:0];
                default: begin
                end
            endcase
        end
    end

    // Read back the addressed register, zero-extended
    always_comb begin
        unique case (reg_idx)
            REG_START_ADDRESS:  prdata = CFG_DATA_W'(r_cfg.start_address);
            REG_END_ADDRESS:    prdata = CFG_DATA_W'(r_cfg.end_address);
            REG_REPEAT_COUNT:   prdata = CFG_DATA_W'(r_cfg.repeat_count);
            REG_REPEAT_ADDRESS: prdata = CFG_DATA_W'(r_cfg.repeat_address);
            REG_NIBBLE_ORDER:   prdata = CFG_DATA_W'(r_cfg.nibble_order);
            REG_PERIOD_SCALE:   prdata = CFG_DATA_W'(r_cfg.period_scale);
            REG_PERIOD:         prdata = CFG_DATA_W'(r_cfg.period);
            REG_VOLUME_SHIFT:   prdata = CFG_DATA_W'(r_cfg.volume_shift);
            default:            prdata = '0;
        endcase
    end

    // Intake: accept and classify each request, hold it in the queue
    nsp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_req    (i_in_req),
        .o_in_stall  (o_in_stall),
        .o_req_valid (req_valid),
        .o_req       (req),
        .i_pop       (pop)
    );

    // Execution: memory, phase accumulator, divider and result register
    nsp_back #(
        .PHASE_CLOCK (PHASE_CLOCK),
        .ADDR_BITS   (ADDR_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_req_valid (req_valid),
        .i_req       (req),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .o_out_res   (o_out_res),
        .i_out_stall (i_out_stall)
    );

endmodule

`default_nettype wire
